FILE: rtl/sha256_byte_stream_hasher_assert.svh
// assertion macros for the sha-256 byte stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sha_pkg.sv
// types, constants and round functions shared by the sha-256 hasher
package sha_pkg;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef logic [31:0] word_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: rtl/sha256_byte_stream_hasher.sv
// top level of the sha-256 byte stream hasher
// Takes a message one byte per word on the input channel and gives the
// 256-bit digest as four 64-bit big-endian words after an end word. Bytes
// are written into a 64-entry block memory; when a block fills, the core
// reads it back into a 16-entry schedule memory, runs 64 rounds at one
// round per cycle and then adds into the chaining words; the top level sees
// done in the cycle after the add, so the word that completes a block holds
// the input stalled until done. Byte words not completing a block, and empty
// words, are taken without a stall. An end word pads one byte per cycle up
// to the end of the block, then compresses it; when the marker byte lands at
// offset 56 or later, a second padded block and another compression follow.
// The four digest words then stream through an output register that may be
// stalled; the next message's input is held until the last digest word is
// taken.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);
  import sha_pkg::*;

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_COMP = 5'b00010,
    T_PAD  = 5'b00100,
    T_WAIT = 5'b01000,
    T_OUT  = 5'b10000
  } top_state_t;

  top_state_t  state;
  logic [5:0]  fill;
  logic [60:0] count;
  logic        ending;
  logic        wrap_pad;
  logic [63:0] bit_len;
  logic        core_start;
  logic        core_done;
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_byte;
  word_t       hash [8];
  logic        hash_reset;
  logic        in_acc;
  logic        out_acc;
  logic [7:0]  pad_byte;

  sha_core u_core (
    .clk, .rst, .start(core_start), .wr_en, .wr_addr, .wr_byte,
    .done(core_done), .hash, .hash_reset
  );

  assign in_stall = (state != T_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign bit_len  = {count, 3'b000};

  // padding byte for the current fill position, length only in the final block
  always_comb begin
    if (fill >= LEN_POS && !wrap_pad) begin
      pad_byte = bit_len[{~fill[2:0], 3'b111} -: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = fill;
    wr_byte    = data_byte;
    core_start = 1'b0;
    if (state == T_IDLE && in_acc && byte_valid) begin
      wr_en = 1'b1;
      core_start = (fill == 6'd63);
    end else if (state == T_PAD) begin
      wr_en = 1'b1;
      // first padding byte of the message is the marker byte
      wr_byte = (ending) ? PAD_BYTE : pad_byte;
      core_start = (fill == 6'd63);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      fill       <= 6'd0;
      count      <= 61'd0;
      ending     <= 1'b0;
      wrap_pad   <= 1'b0;
      out_valid  <= 1'b0;
      hash_reset <= 1'b0;
    end else begin
      // chaining words go back to the initial values once the digest is out
      hash_reset <= (state == T_OUT) && out_acc && last_word;
      case (state)
        T_IDLE: begin
          if (in_acc) begin
            if (byte_valid) begin
              fill  <= fill + 6'd1;
              count <= count + 61'd1;
            end
            if (end_of_message) begin
              ending <= 1'b1;
            end
            if (byte_valid && fill == 6'd63) begin
              state <= T_COMP;
            end else if (end_of_message) begin
              state <= T_PAD;
            end
          end
        end
        T_COMP: begin
          // padding still owed after this block goes back to T_PAD
          if (core_done) begin
            state    <= (ending || wrap_pad) ? T_PAD : T_IDLE;
            wrap_pad <= 1'b0;
          end
        end
        T_PAD: begin
          ending <= 1'b0;
          fill   <= fill + 6'd1;
          // marker too late for the length field, so one more block follows
          if (ending && fill >= LEN_POS) begin
            wrap_pad <= 1'b1;
          end
          if (fill == 6'd63) begin
            state <= (ending || wrap_pad) ? T_COMP : T_WAIT;
          end
        end
        T_WAIT: begin
          if (core_done) begin
            state       <= T_OUT;
            out_valid   <= 1'b1;
            word_index  <= 2'd0;
            digest_word <= {hash[0], hash[1]};
            last_word   <= 1'b0;
          end
        end
        T_OUT: begin
          if (out_acc) begin
            if (last_word) begin
              out_valid <= 1'b0;
              state     <= T_IDLE;
              fill      <= 6'd0;
              count     <= 61'd0;
            end else begin
              word_index  <= word_index + 2'd1;
              digest_word <= {hash[{word_index + 2'd1, 1'b0}],
                              hash[{word_index + 2'd1, 1'b1}]};
              last_word   <= (word_index == 2'd2);
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  `include "sha256_byte_stream_hasher_assert.svh"

  `SHA_ASSERT_IMP(a_no_in_when_out, out_valid, in_stall, "input open while digest pending")
  `SHA_ASSERT_IMP(a_last_idx, out_valid && last_word, word_index == 2'd3, "last word index")
  `SHA_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid, "digest word dropped")

endmodule

FILE: rtl/sha_core.sv
// sha-256 compression: block and schedule in memories, one round per cycle
module sha_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               wr_en,
  input  logic [5:0]         wr_addr,
  input  logic [7:0]         wr_byte,
  output logic               done,
  output sha_pkg::word_t     hash [8],
  input  logic               hash_reset
);
  import sha_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_RUN  = 4'b0100,
    S_ADD  = 4'b1000
  } core_state_t;

  core_state_t state;
  logic [7:0]  block_mem [64];
  word_t       w_mem [16];
  logic [5:0]  rd_idx;
  logic [4:0]  load_cnt;
  logic [6:0]  round;
  word_t       ld_word;
  word_t       a, b, c, d, e, f, g, h;
  word_t       w15, w2, w7, w16;
  word_t       w_cur, t1, t2;
  logic [3:0]  ri;

  // block byte memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      block_mem[wr_addr] <= wr_byte;
    end
    ld_word <= {ld_word[23:0], block_mem[rd_idx]};
  end

  assign ri = round[3:0];
  assign w16 = w_mem[ri];
  assign w15 = w_mem[ri + 4'd1];
  assign w7  = w_mem[ri + 4'd9];
  assign w2  = w_mem[ri + 4'd14];
  assign w_cur = (round < 7'd16) ? w16 : (w16 + sig0(w15) + w7 + sig1(w2));

  always_comb begin
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + K_TAB[round[5:0]] + w_cur;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      for (int i = 0; i < 8; i++) hash[i] <= H_INIT[i];
    end else begin
      done <= (state == S_ADD);
      if (hash_reset) begin
        for (int i = 0; i < 8; i++) hash[i] <= H_INIT[i];
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            state    <= S_LOAD;
            rd_idx   <= 6'd0;
            load_cnt <= 5'd0;
          end
        end
        S_LOAD: begin
          // 64 byte reads, a word lands from the registered read after every fourth byte
          rd_idx <= rd_idx + 6'd1;
          if (rd_idx[1:0] == 2'd0 && load_cnt != 5'd0) begin
            w_mem[load_cnt[3:0] - 4'd1] <= ld_word;
          end
          if (rd_idx[1:0] == 2'd0) load_cnt <= load_cnt + 5'd1;
          if (load_cnt == 5'd16 && rd_idx[1:0] == 2'd0) begin
            state <= S_RUN;
            round <= 7'd0;
            {a, b, c, d, e, f, g, h} <= {hash[0], hash[1], hash[2], hash[3],
                                         hash[4], hash[5], hash[6], hash[7]};
          end
        end
        S_RUN: begin
          w_mem[ri] <= w_cur;
          h <= g; g <= f; f <= e; e <= d + t1;
          d <= c; c <= b; b <= a; a <= t1 + t2;
          round <= round + 7'd1;
          if (round == 7'd63) state <= S_ADD;
        end
        S_ADD: begin
          hash[0] <= hash[0] + a; hash[1] <= hash[1] + b;
          hash[2] <= hash[2] + c; hash[3] <= hash[3] + d;
          hash[4] <= hash[4] + e; hash[5] <= hash[5] + f;
          hash[6] <= hash[6] + g; hash[7] <= hash[7] + h;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
